// File: src/lom_pkg.sv
// Shared types and codes for the limit order matcher.
package lom_pkg;

   localparam int REQ_W = 2;
   localparam int STATUS_W = 3;
   localparam int ARRIVAL_W = 32;

   typedef enum logic [REQ_W-1:0] {
      REQ_NEW_BID    = 2'd0,
      REQ_NEW_ASK    = 2'd1,
      REQ_CANCEL_BID = 2'd2,
      REQ_CANCEL_ASK = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_FILL       = 3'd0,
      ST_RESTED     = 3'd1,
      ST_FILLED     = 3'd2,
      ST_CXL_REMOVE = 3'd3,
      ST_CXL_REDUCE = 3'd4,
      ST_CXL_LARGE  = 3'd5,
      ST_NOT_FOUND  = 3'd6,
      ST_BOOK_FULL  = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_EMIT,
      S_WRITE
   } state_type;

   // Command from the controller to every cell of one side.
   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_CLEAR,
      CMD_SET_QTY,
      CMD_LOAD
   } cell_cmd_type;

endpackage

// File: src/lom_cell.sv
// One book slot: holds an order and folds its candidacy into the passing scan token.
module lom_cell #(
   parameter int TRADER_BITS = 16,
   parameter int PRICE_BITS = 24,
   parameter int QTY_BITS = 16,
   parameter int IDX_W = 5
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [IDX_W-1:0]             my_idx,
   // scan mode: 0 best match (buying selects lowest), 1 cancel lookup
   input  logic                         scan_cancel,
   input  logic                         buying,
   input  logic [TRADER_BITS-1:0]       key_owner,
   input  logic [PRICE_BITS-1:0]        key_price,
   // incoming token
   input  logic                         tin_found,
   input  logic [IDX_W-1:0]             tin_idx,
   input  logic [PRICE_BITS-1:0]        tin_price,
   input  logic [lom_pkg::ARRIVAL_W-1:0] tin_arr,
   input  logic                         tin_free_found,
   input  logic [IDX_W-1:0]             tin_free_idx,
   // outgoing token, registered
   output logic                         tout_found,
   output logic [IDX_W-1:0]             tout_idx,
   output logic [PRICE_BITS-1:0]        tout_price,
   output logic [lom_pkg::ARRIVAL_W-1:0] tout_arr,
   output logic                         tout_free_found,
   output logic [IDX_W-1:0]             tout_free_idx,
   // update port
   input  lom_pkg::cell_cmd_type        cmd,
   input  logic [IDX_W-1:0]             cmd_idx,
   input  logic [TRADER_BITS-1:0]       wr_owner,
   input  logic [PRICE_BITS-1:0]        wr_price,
   input  logic [QTY_BITS-1:0]          wr_qty,
   input  logic [lom_pkg::ARRIVAL_W-1:0] wr_arr,
   // contents, read by the controller through a mux at the chosen index
   output logic [TRADER_BITS-1:0]       owner,
   output logic [QTY_BITS-1:0]          qty
);
   import lom_pkg::*;

   logic                  valid_ff;
   logic [TRADER_BITS-1:0] owner_ff;
   logic [PRICE_BITS-1:0] price_ff;
   logic [QTY_BITS-1:0]   qty_ff;
   logic [ARRIVAL_W-1:0]  arr_ff;
   logic                  elig;
   logic                  better;
   logic                  hit;

   always_comb begin
      if (scan_cancel) begin
         elig = valid_ff && owner_ff == key_owner && price_ff == key_price;
         better = arr_ff < tin_arr;
      end else begin
         elig = valid_ff && (buying ? !(key_price < price_ff) : !(key_price > price_ff));
         if (price_ff == tin_price) better = arr_ff < tin_arr;
         else better = buying ? (price_ff < tin_price) : (price_ff > tin_price);
      end
      hit = cmd_idx == my_idx;
   end

   always_ff @(posedge clock) begin
      if (elig && (!tin_found || better)) begin
         tout_found <= 1'b1;
         tout_idx   <= my_idx;
         tout_price <= price_ff;
         tout_arr   <= arr_ff;
      end else begin
         tout_found <= tin_found;
         tout_idx   <= tin_idx;
         tout_price <= tin_price;
         tout_arr   <= tin_arr;
      end
      if (!valid_ff && !tin_free_found) begin
         tout_free_found <= 1'b1;
         tout_free_idx   <= my_idx;
      end else begin
         tout_free_found <= tin_free_found;
         tout_free_idx   <= tin_free_idx;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (hit) begin
         case (cmd)
            CMD_CLEAR: valid_ff <= 1'b0;
            CMD_LOAD:  valid_ff <= 1'b1;
            default:   valid_ff <= valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (hit && cmd == CMD_LOAD) begin
         owner_ff <= wr_owner;
         price_ff <= wr_price;
         arr_ff   <= wr_arr;
      end
      if (hit && (cmd == CMD_LOAD || cmd == CMD_SET_QTY)) qty_ff <= wr_qty;
   end

   assign owner = owner_ff;
   assign qty   = qty_ff;

endmodule

// File: src/lom_side.sv
// One side of the book: a chain of slot cells with its scan token.
module lom_side #(
   parameter int DEPTH = 32,
   parameter int TRADER_BITS = 16,
   parameter int PRICE_BITS = 24,
   parameter int QTY_BITS = 16,
   parameter int IDX_W = 5
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          scan_cancel,
   input  logic                          buying,
   input  logic [TRADER_BITS-1:0]        key_owner,
   input  logic [PRICE_BITS-1:0]         key_price,
   input  lom_pkg::cell_cmd_type         cmd,
   input  logic [IDX_W-1:0]              cmd_idx,
   input  logic [TRADER_BITS-1:0]        wr_owner,
   input  logic [PRICE_BITS-1:0]         wr_price,
   input  logic [QTY_BITS-1:0]           wr_qty,
   input  logic [lom_pkg::ARRIVAL_W-1:0] wr_arr,
   output logic                          found,
   output logic [IDX_W-1:0]              found_idx,
   output logic [PRICE_BITS-1:0]         found_price,
   output logic                          free_found,
   output logic [IDX_W-1:0]              free_idx,
   output logic [TRADER_BITS-1:0]        sel_owner,
   output logic [QTY_BITS-1:0]           sel_qty
);
   import lom_pkg::*;

   logic                  t_found [DEPTH+1];
   logic [IDX_W-1:0]      t_idx   [DEPTH+1];
   logic [PRICE_BITS-1:0] t_price [DEPTH+1];
   logic [ARRIVAL_W-1:0]  t_arr   [DEPTH+1];
   logic                  t_ff    [DEPTH+1];
   logic [IDX_W-1:0]      t_fidx  [DEPTH+1];
   logic [TRADER_BITS-1:0] c_owner [DEPTH];
   logic [QTY_BITS-1:0]   c_qty   [DEPTH];

   assign t_found[0] = 1'b0;
   assign t_idx[0]   = '0;
   assign t_price[0] = '0;
   assign t_arr[0]   = '0;
   assign t_ff[0]    = 1'b0;
   assign t_fidx[0]  = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      lom_cell #(
         .TRADER_BITS(TRADER_BITS), .PRICE_BITS(PRICE_BITS),
         .QTY_BITS(QTY_BITS), .IDX_W(IDX_W)
      ) u_cell (
         .clock, .reset,
         .my_idx(IDX_W'(g)),
         .scan_cancel, .buying, .key_owner, .key_price,
         .tin_found(t_found[g]), .tin_idx(t_idx[g]), .tin_price(t_price[g]),
         .tin_arr(t_arr[g]), .tin_free_found(t_ff[g]), .tin_free_idx(t_fidx[g]),
         .tout_found(t_found[g+1]), .tout_idx(t_idx[g+1]),
         .tout_price(t_price[g+1]), .tout_arr(t_arr[g+1]),
         .tout_free_found(t_ff[g+1]), .tout_free_idx(t_fidx[g+1]),
         .cmd, .cmd_idx, .wr_owner, .wr_price, .wr_qty, .wr_arr,
         .owner(c_owner[g]), .qty(c_qty[g])
      );
   end

   assign found       = t_found[DEPTH];
   assign found_idx   = t_idx[DEPTH];
   assign found_price = t_price[DEPTH];
   assign free_found  = t_ff[DEPTH];
   assign free_idx    = t_fidx[DEPTH];
   assign sel_owner   = c_owner[found_idx];
   assign sel_qty     = c_qty[found_idx];

endmodule

// File: src/limit_order_matcher_unit.sv
// Limit order matcher: price-time priority book with bid and ask slot chains.
//
// Each side is a chain of BOOK_DEPTH slot cells. A scan token enters the first
// cell and moves one cell per cycle; each cell replaces the token's candidate
// when it holds a better eligible order, and notes the first empty slot. A
// scan therefore passes the whole chain; then the decide state reads the
// chosen slot, the emit state presents the result and the write state
// updates the slot. A new order costs (fills + 1) scans and a cancel one
// scan; the result waits in the emit state while rsp_stall is high.
// Only one request is in the unit at a time: req_stall stays high from
// acceptance until the slot update cycle that follows the transfer of the
// final result (last = 1). Status codes are fill, rested, fully filled,
// cancel removed, cancel reduced, cancel too large, not found and book full.
// The book is empty after reset; no clearing pass is needed as only the valid
// bits are reset.
module limit_order_matcher_unit #(
   parameter int BOOK_DEPTH = 32,
   parameter int PRICE_BITS = 24,
   parameter int QTY_BITS = 16,
   parameter int TRADER_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_type,
   input  logic [TRADER_BITS-1:0]   req_trader_id,
   input  logic [PRICE_BITS-1:0]    req_limit_price,
   input  logic [QTY_BITS-1:0]      req_order_qty,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [2:0]               rsp_status,
   output logic [TRADER_BITS-1:0]   rsp_counterparty_id,
   output logic [PRICE_BITS-1:0]    rsp_fill_price,
   output logic [QTY_BITS-1:0]      rsp_fill_qty,
   output logic [QTY_BITS-1:0]      rsp_remaining_qty,
   output logic                     rsp_last
);
   import lom_pkg::*;

   localparam int IDX_W = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
   localparam int CNT_W = $clog2(BOOK_DEPTH + 1);

   state_type state_ff, state_in;

   // Latched request
   logic [1:0]             type_ff;
   logic [TRADER_BITS-1:0] trader_ff;
   logic [PRICE_BITS-1:0]  limit_ff;
   logic [QTY_BITS-1:0]    rem_ff, rem_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [CNT_W-1:0]       fills_ff;

   logic [ARRIVAL_W-1:0] bid_cnt_ff, ask_cnt_ff;

   // Result register
   logic [2:0]             st_ff, st_in;
   logic [TRADER_BITS-1:0] cp_ff, cp_in;
   logic [PRICE_BITS-1:0]  fp_ff, fp_in;
   logic [QTY_BITS-1:0]    fq_ff, fq_in;
   logic [QTY_BITS-1:0]    rq_ff, rq_in;
   logic                   last_ff, last_in;

   // Pending slot update, applied in S_WRITE
   cell_cmd_type           pcmd_ff, pcmd_in;
   logic                   pbid_ff, pbid_in;
   logic [IDX_W-1:0]       pidx_ff, pidx_in;
   logic [QTY_BITS-1:0]    pqty_ff, pqty_in;

   logic is_new, buying, scan_bid_side;
   logic req_xfer, rsp_xfer;

   // side ports
   cell_cmd_type bid_cmd, ask_cmd;
   logic bid_found, ask_found, bid_ff_found, ask_ff_found;
   logic [IDX_W-1:0] bid_fidx, ask_fidx, bid_free, ask_free;
   logic [PRICE_BITS-1:0] bid_fprice, ask_fprice;
   logic [TRADER_BITS-1:0] bid_owner, ask_owner;
   logic [QTY_BITS-1:0] bid_qty, ask_qty;

   logic                   s_found, s_free_found;
   logic [IDX_W-1:0]       s_idx, s_free;
   logic [PRICE_BITS-1:0]  s_price;
   logic [TRADER_BITS-1:0] s_owner;
   logic [QTY_BITS-1:0]    s_qty;

   assign is_new = type_ff == REQ_NEW_BID || type_ff == REQ_NEW_ASK;
   assign buying = type_ff == REQ_NEW_BID;
   // new bid scans asks; cancel bid scans bids
   assign scan_bid_side = (type_ff == REQ_NEW_ASK) || (type_ff == REQ_CANCEL_BID);

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      bid_cmd = CMD_NONE;
      ask_cmd = CMD_NONE;
      if (state_ff == S_WRITE) begin
         if (pbid_ff) bid_cmd = pcmd_ff;
         else ask_cmd = pcmd_ff;
      end
   end

   // The resting side of a new order, loaded with the remainder.
   logic own_bid;
   logic [ARRIVAL_W-1:0] own_cnt;
   assign own_bid = buying;
   assign own_cnt = own_bid ? bid_cnt_ff : ask_cnt_ff;

   lom_side #(
      .DEPTH(BOOK_DEPTH), .TRADER_BITS(TRADER_BITS), .PRICE_BITS(PRICE_BITS),
      .QTY_BITS(QTY_BITS), .IDX_W(IDX_W)
   ) u_bid (
      .clock, .reset,
      .scan_cancel(!is_new), .buying(1'b0),
      .key_owner(trader_ff), .key_price(limit_ff),
      .cmd(bid_cmd), .cmd_idx(pidx_ff),
      .wr_owner(trader_ff), .wr_price(limit_ff), .wr_qty(pqty_ff), .wr_arr(own_cnt),
      .found(bid_found), .found_idx(bid_fidx), .found_price(bid_fprice),
      .free_found(bid_ff_found), .free_idx(bid_free),
      .sel_owner(bid_owner), .sel_qty(bid_qty)
   );

   lom_side #(
      .DEPTH(BOOK_DEPTH), .TRADER_BITS(TRADER_BITS), .PRICE_BITS(PRICE_BITS),
      .QTY_BITS(QTY_BITS), .IDX_W(IDX_W)
   ) u_ask (
      .clock, .reset,
      .scan_cancel(!is_new), .buying(1'b1),
      .key_owner(trader_ff), .key_price(limit_ff),
      .cmd(ask_cmd), .cmd_idx(pidx_ff),
      .wr_owner(trader_ff), .wr_price(limit_ff), .wr_qty(pqty_ff), .wr_arr(own_cnt),
      .found(ask_found), .found_idx(ask_fidx), .found_price(ask_fprice),
      .free_found(ask_ff_found), .free_idx(ask_free),
      .sel_owner(ask_owner), .sel_qty(ask_qty)
   );

   always_comb begin
      if (scan_bid_side) begin
         s_found = bid_found; s_idx = bid_fidx; s_price = bid_fprice;
         s_owner = bid_owner; s_qty = bid_qty;
      end else begin
         s_found = ask_found; s_idx = ask_fidx; s_price = ask_fprice;
         s_owner = ask_owner; s_qty = ask_qty;
      end
      if (own_bid) begin
         s_free_found = bid_ff_found; s_free = bid_free;
      end else begin
         s_free_found = ask_ff_found; s_free = ask_free;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_xfer) state_in = S_SCAN;
         S_SCAN:   if (cnt_ff == CNT_W'(BOOK_DEPTH - 1)) state_in = S_DECIDE;
         S_DECIDE: state_in = S_EMIT;
         S_EMIT:   if (rsp_xfer) state_in = S_WRITE;
         S_WRITE:  state_in = last_ff ? S_IDLE : S_SCAN;
         default:  state_in = S_IDLE;
      endcase
   end

   // Decide: form result and the pending update
   always_comb begin
      st_in = st_ff; cp_in = cp_ff; fp_in = fp_ff; fq_in = fq_ff;
      rq_in = rq_ff; last_in = last_ff; rem_in = rem_ff;
      pcmd_in = pcmd_ff; pbid_in = pbid_ff; pidx_in = pidx_ff; pqty_in = pqty_ff;
      if (state_ff == S_DECIDE) begin
         cp_in = '0; fp_in = '0; fq_in = '0; last_in = 1'b1;
         pcmd_in = CMD_NONE; pbid_in = scan_bid_side; pidx_in = s_idx; pqty_in = s_qty;
         if (!is_new) begin
            if (!s_found) begin
               st_in = ST_NOT_FOUND; rq_in = '0;
            end else if (s_qty == rem_ff) begin
               st_in = ST_CXL_REMOVE; rq_in = '0; pcmd_in = CMD_CLEAR;
            end else if (s_qty > rem_ff) begin
               st_in = ST_CXL_REDUCE; rq_in = s_qty - rem_ff;
               pcmd_in = CMD_SET_QTY; pqty_in = s_qty - rem_ff;
            end else begin
               st_in = ST_CXL_LARGE; rq_in = s_qty;
            end
         end else if (rem_ff != '0 && s_found && fills_ff != CNT_W'(BOOK_DEPTH)) begin
            st_in = ST_FILL; cp_in = s_owner; fp_in = s_price; last_in = 1'b0;
            if (s_qty > rem_ff) begin
               fq_in = rem_ff; rem_in = '0;
               pcmd_in = CMD_SET_QTY; pqty_in = s_qty - rem_ff;
            end else begin
               fq_in = s_qty; rem_in = rem_ff - s_qty; pcmd_in = CMD_CLEAR;
            end
            rq_in = rem_in;
         end else if (rem_ff == '0) begin
            st_in = ST_FILLED; rq_in = '0;
         end else if (s_free_found) begin
            st_in = ST_RESTED; rq_in = rem_ff;
            pcmd_in = CMD_LOAD; pbid_in = own_bid; pidx_in = s_free; pqty_in = rem_ff;
         end else begin
            st_in = ST_BOOK_FULL; rq_in = rem_ff;
         end
      end
   end

   // Outputs
   always_comb begin
      req_stall = state_ff != S_IDLE;
      rsp_valid = state_ff == S_EMIT;
   end

   assign rsp_status          = st_ff;
   assign rsp_counterparty_id = cp_ff;
   assign rsp_fill_price      = fp_ff;
   assign rsp_fill_qty        = fq_ff;
   assign rsp_remaining_qty   = rq_ff;
   assign rsp_last            = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         bid_cnt_ff <= '0;
         ask_cnt_ff <= '0;
         pcmd_ff    <= CMD_NONE;
      end else begin
         state_ff <= state_in;
         pcmd_ff  <= pcmd_in;
         if (state_ff == S_WRITE && pcmd_ff == CMD_LOAD) begin
            if (pbid_ff) bid_cnt_ff <= bid_cnt_ff + 1'b1;
            else ask_cnt_ff <= ask_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         type_ff   <= req_type;
         trader_ff <= req_trader_id;
         limit_ff  <= req_limit_price;
         rem_ff    <= req_order_qty;
         fills_ff  <= '0;
      end else begin
         rem_ff <= rem_in;
         if (state_ff == S_DECIDE && st_in == ST_FILL) fills_ff <= fills_ff + 1'b1;
      end
      if (state_ff == S_SCAN) cnt_ff <= cnt_ff + 1'b1;
      else cnt_ff <= '0;
      st_ff <= st_in; cp_ff <= cp_in; fp_ff <= fp_in; fq_ff <= fq_in;
      rq_ff <= rq_in; last_ff <= last_in;
      pbid_ff <= pbid_in; pidx_ff <= pidx_in; pqty_ff <= pqty_in;
   end

`ifndef ASSERT_OFF
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("result shown while idle");
   a_fill_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FILL) |-> !rsp_last)
      else $error("fill flagged last");
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) |=> ##1 !req_stall)
      else $error("not idle after final transfer");
   a_fill_qty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FILL) |-> rsp_fill_qty != '0)
      else $error("empty fill");
`endif

endmodule

// File: bench/tb.sv
// Self-checking testbench for the limit order matcher unit.
module tb;
   import lom_pkg::*;

   localparam int DEPTH = 32;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 4 * (DEPTH + 4);
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      status_type  status;
      logic [15:0] counterparty;
      logic [23:0] price;
      logic [15:0] fill_qty;
      logic [15:0] remaining;
      logic        last;
   } book_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_type = '0;
   logic [15:0] req_trader_id = '0;
   logic [23:0] req_limit_price = '0;
   logic [15:0] req_order_qty = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_counterparty_id;
   logic [23:0] rsp_fill_price;
   logic [15:0] rsp_fill_qty;
   logic [15:0] rsp_remaining_qty;
   logic        rsp_last;

   // Book mirror: index 0 is the bid side, 1 the ask side.
   logic        slot_live [2][DEPTH];
   logic [15:0] slot_owner[2][DEPTH];
   logic [23:0] slot_price[2][DEPTH];
   logic [15:0] slot_qty  [2][DEPTH];
   logic [31:0] slot_seq  [2][DEPTH];
   logic [31:0] seq_count [2];

   book_result_type pending_results[$];
   int fail_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   int hold_reqs = 0;
   int hold_seen = 0;
   bit idle_on = 1'b1;

   limit_order_matcher_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
      .req_trader_id(req_trader_id), .req_limit_price(req_limit_price),
      .req_order_qty(req_order_qty),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_counterparty_id(rsp_counterparty_id), .rsp_fill_price(rsp_fill_price),
      .rsp_fill_qty(rsp_fill_qty), .rsp_remaining_qty(rsp_remaining_qty),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Long receiver hold-off, started on request and counted down in cycles.
   always @(posedge clock) begin
      if (hold_reqs != hold_seen) begin
         hold_seen <= hold_reqs;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Receiver: random stall, and check each transfer against the oldest expectation.
   always @(posedge clock) begin
      book_result_type want;
      rsp_stall <= (hold_left != 0) || (idle_on && $urandom_range(99) < 24);
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with nothing expected, status %0d", rsp_status);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_counterparty_id !== want.counterparty) begin
               $error("counterparty_id: expected %0d, got %0d",
                      want.counterparty, rsp_counterparty_id);
               fail_count++;
            end
            if (rsp_fill_price !== want.price) begin
               $error("fill_price: expected %0d, got %0d", want.price, rsp_fill_price);
               fail_count++;
            end
            if (rsp_fill_qty !== want.fill_qty) begin
               $error("fill_qty: expected %0d, got %0d", want.fill_qty, rsp_fill_qty);
               fail_count++;
            end
            if (rsp_remaining_qty !== want.remaining) begin
               $error("remaining_qty: expected %0d, got %0d",
                      want.remaining, rsp_remaining_qty);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   function automatic void push_result(status_type st, logic [15:0] cp, logic [23:0] pr,
                                       logic [15:0] fq, logic [15:0] rem, logic lst);
      book_result_type r;
      r.status = st; r.counterparty = cp; r.price = pr;
      r.fill_qty = fq; r.remaining = rem; r.last = lst;
      pending_results.insert(pending_results.size(), r);
   endfunction

   // New order: walk the opposite side in price-time order, then rest the remainder or report book full.
   function automatic void match_order(bit buying, logic [15:0] trader,
                                       logic [23:0] limit, logic [15:0] qty);
      int own;
      int opp;
      int best;
      int fills;
      logic [15:0] rem;
      logic [15:0] take;
      own = buying ? 0 : 1;
      opp = 1 - own;
      rem = qty;
      fills = 0;
      while (rem != 0 && fills < DEPTH) begin
         best = -1;
         for (int i = 0; i < DEPTH; i++) begin
            if (!slot_live[opp][i]) continue;
            if (buying ? (limit < slot_price[opp][i]) : (limit > slot_price[opp][i]))
               continue;
            if (best < 0) best = i;
            else if (slot_price[opp][i] == slot_price[opp][best]) begin
               if (slot_seq[opp][i] < slot_seq[opp][best]) best = i;
            end else if (buying ? (slot_price[opp][i] < slot_price[opp][best])
                                : (slot_price[opp][i] > slot_price[opp][best]))
               best = i;
         end
         if (best < 0) break;
         if (slot_qty[opp][best] > rem) begin
            take = rem;
            slot_qty[opp][best] -= rem;
         end else begin
            take = slot_qty[opp][best];
            slot_live[opp][best] = 1'b0;
         end
         rem -= take;
         push_result(ST_FILL, slot_owner[opp][best], slot_price[opp][best], take, rem, 1'b0);
         fills++;
      end
      if (rem == 0) begin
         push_result(ST_FILLED, '0, '0, '0, '0, 1'b1);
         return;
      end
      for (int i = 0; i < DEPTH; i++) begin
         if (!slot_live[own][i]) begin
            slot_live[own][i] = 1'b1;
            slot_owner[own][i] = trader;
            slot_price[own][i] = limit;
            slot_qty[own][i] = rem;
            slot_seq[own][i] = seq_count[own];
            seq_count[own] += 32'd1;
            push_result(ST_RESTED, '0, '0, '0, rem, 1'b1);
            return;
         end
      end
      push_result(ST_BOOK_FULL, '0, '0, '0, rem, 1'b1);
   endfunction

   // Cancel: earliest order of this owner at this price on one side.
   function automatic void cancel_order(int side, logic [15:0] trader,
                                        logic [23:0] limit, logic [15:0] qty);
      int hit;
      hit = -1;
      for (int i = 0; i < DEPTH; i++) begin
         if (!slot_live[side][i] || slot_owner[side][i] != trader ||
             slot_price[side][i] != limit) continue;
         if (hit < 0 || slot_seq[side][i] < slot_seq[side][hit]) hit = i;
      end
      if (hit < 0)
         push_result(ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
      else if (slot_qty[side][hit] == qty) begin
         slot_live[side][hit] = 1'b0;
         push_result(ST_CXL_REMOVE, '0, '0, '0, '0, 1'b1);
      end else if (slot_qty[side][hit] > qty) begin
         slot_qty[side][hit] -= qty;
         push_result(ST_CXL_REDUCE, '0, '0, '0, slot_qty[side][hit], 1'b1);
      end else
         push_result(ST_CXL_LARGE, '0, '0, '0, slot_qty[side][hit], 1'b1);
   endfunction

   // One request transfer; valid stays high between back-to-back requests.
   task automatic send_request(req_code_type code, logic [15:0] trader,
                               logic [23:0] limit, logic [15:0] qty);
      if (idle_on && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_type <= code;
      req_trader_id <= trader;
      req_limit_price <= limit;
      req_order_qty <= qty;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      case (code)
         REQ_NEW_BID:    match_order(1'b1, trader, limit, qty);
         REQ_NEW_ASK:    match_order(1'b0, trader, limit, qty);
         REQ_CANCEL_BID: cancel_order(0, trader, limit, qty);
         default:        cancel_order(1, trader, limit, qty);
      endcase
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // Extremes, every request type and each cancel outcome.
   task automatic test_directed();
      send_request(REQ_NEW_BID, 16'd1, 24'd100, 16'd0);          // zero quantity
      send_request(REQ_NEW_BID, 16'hFFFF, 24'hFFFFFF, 16'hFFFF); // all ones rests
      send_request(REQ_NEW_ASK, 16'd0, 24'd0, 16'hFFFF);         // fully fills it
      send_request(REQ_NEW_ASK, 16'd2, 24'd200, 16'd10);
      send_request(REQ_NEW_ASK, 16'd3, 24'd200, 16'd5);          // same price, later
      send_request(REQ_NEW_ASK, 16'd4, 24'd190, 16'd7);          // better price
      send_request(REQ_NEW_BID, 16'd5, 24'd200, 16'd20);         // walks three asks
      send_request(REQ_NEW_BID, 16'd6, 24'd150, 16'd8);
      send_request(REQ_NEW_BID, 16'd6, 24'd150, 16'd9);          // same owner and price
      send_request(REQ_CANCEL_BID, 16'd6, 24'd150, 16'd3);       // reduce earliest
      send_request(REQ_CANCEL_BID, 16'd6, 24'd150, 16'd5);       // remove it
      send_request(REQ_CANCEL_BID, 16'd6, 24'd150, 16'd50);      // too large
      send_request(REQ_CANCEL_BID, 16'd6, 24'd150, 16'd0);       // zero reduces nothing
      send_request(REQ_CANCEL_BID, 16'd7, 24'd150, 16'd1);       // not found
      send_request(REQ_NEW_ASK, 16'd8, 24'd300, 16'd4);
      send_request(REQ_CANCEL_ASK, 16'd8, 24'd300, 16'd4);
      send_request(REQ_CANCEL_ASK, 16'd8, 24'd300, 16'd4);       // gone now
      send_request(REQ_NEW_ASK, 16'd9, 24'd140, 16'd30);         // hits bid, rests rest
      send_request(REQ_CANCEL_ASK, 16'd9, 24'd140, 16'hFFFF);
      send_request(REQ_NEW_BID, 16'd10, 24'd140, 16'd40);
   endtask

   // Fill the bid side, overflow it, then sweep it with one large ask.
   task automatic test_book_full();
      bit full;
      int sweep_slot;
      full = 1'b0;
      while (!full) begin
         send_request(REQ_NEW_BID, 16'($urandom_range(20, 23)), 24'd50, 16'd3);
         full = 1'b1;
         for (int i = 0; i < DEPTH; i++) full &= slot_live[0][i];
      end
      send_request(REQ_NEW_BID, 16'd24, 24'd40, 16'd11);
      send_request(REQ_NEW_ASK, 16'd25, 24'd0, 16'hFFFF);
      wait_drained();
      sweep_slot = -1;
      for (int i = 0; i < DEPTH; i++)
         if (slot_live[1][i] && slot_owner[1][i] == 16'd25 && slot_price[1][i] == 24'd0)
            sweep_slot = i;
      if (sweep_slot >= 0)
         send_request(REQ_CANCEL_ASK, 16'd25, 24'd0, slot_qty[1][sweep_slot]);
   endtask

   // Receiver holds off while requests keep coming, so the unit stalls its input.
   task automatic test_backpressure();
      hold_reqs++;
      for (int n = 0; n < 8; n++)
         send_request(n[0] ? REQ_NEW_ASK : REQ_NEW_BID, 16'(n), 24'd1000, 16'd5);
      wait_drained();
   endtask

   task automatic random_request();
      int pick;
      int side;
      int slot;
      int tries;
      logic [15:0] trader;
      logic [23:0] limit;
      logic [15:0] qty;
      pick = $urandom_range(99);
      trader = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
      limit = ($urandom_range(19) == 0) ? 24'($urandom) : 24'(1000 + $urandom_range(0, 16) - 8);
      case ($urandom_range(19))
         0:       qty = '0;
         1:       qty = 16'($urandom);
         default: qty = 16'($urandom_range(1, 50));
      endcase
      if (pick < 40)
         send_request(REQ_NEW_BID, trader, limit, qty);
      else if (pick < 80)
         send_request(REQ_NEW_ASK, trader, limit, qty);
      else begin
         side = $urandom_range(1);
         slot = -1;
         for (tries = 0; tries < 8 && slot < 0; tries++) begin
            slot = $urandom_range(DEPTH - 1);
            if (!slot_live[side][slot]) slot = -1;
         end
         if (slot >= 0 && $urandom_range(4) != 0) begin
            trader = slot_owner[side][slot];
            limit = slot_price[side][slot];
            case ($urandom_range(3))
               0: qty = slot_qty[side][slot];
               1: qty = 16'($urandom_range(0, slot_qty[side][slot]));
               2: qty = slot_qty[side][slot] + 16'($urandom_range(1, 20));
               default: qty = 16'($urandom);
            endcase
         end
         send_request(side ? REQ_CANCEL_ASK : REQ_CANCEL_BID, trader, limit, qty);
      end
   endtask

   // Random traffic: a stretch with no idling, then a drain pause, then idling on.
   task automatic test_random();
      idle_on = 1'b0;
      for (int n = 0; n < 100; n++) random_request();
      idle_on = 1'b1;
      wait_drained();
      for (int n = 0; n < 240; n++) random_request();
   endtask

   initial begin
      for (int s = 0; s < 2; s++) begin
         seq_count[s] = '0;
         for (int i = 0; i < DEPTH; i++) slot_live[s][i] = 1'b0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_book_full();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
